// File: design/phs_pkg.sv
// Shared constants and types for the pick hit record selector.
`timescale 1ns / 1ps
package phs_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned PHS_MAX_NAMES = 8;
  localparam int unsigned OUT_MAX       = 8;
  localparam int unsigned POS_W         = 3;
  localparam int unsigned CNT_W         = 4;

  // Sort mode codes held in the configuration register
  localparam logic [1:0] MODE_LEAST  = 2'd0;
  localparam logic [1:0] MODE_MOST   = 2'd1;
  localparam logic [1:0] MODE_SECOND = 2'd2;
  localparam logic [1:0] MODE_DEPTH  = 2'd3;

  // Chosen list handed from the record parser to the result burst stage
  typedef struct packed {
    logic [CNT_W-1:0]               count;
    logic [OUT_MAX-1:0][WORD_W-1:0] names;
  } phs_snap_t;

endpackage

// File: design/phs_in_if.sv
// Input channel: one hit buffer word per item.
`timescale 1ns / 1ps
interface phs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink (input valid, input word, input last_word, output ready);
endinterface

// File: design/phs_out_if.sv
// Result channel: one name of the chosen list per item.
`timescale 1ns / 1ps
interface phs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] name_value;
  logic [2:0]  name_position;
  logic        last_name;

  modport source (output valid, output found, output name_value, output name_position,
                  output last_name, input ready);
  modport sink (input valid, input found, input name_value, input name_position,
                input last_name, output ready);
endinterface

// File: design/phs_cfg_if.sv
// Configuration write channel carrying the sort mode.
`timescale 1ns / 1ps
interface phs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] sort_mode;

  modport source (output valid, output sort_mode, input ready);
  modport sink (input valid, input sort_mode, output ready);
endinterface

// File: design/phs_parser.sv
// Hit record parser: walks the records and keeps the best name list.
`timescale 1ns / 1ps
module phs_parser
  import phs_pkg::*;
#(
  parameter int unsigned MAX_NAMES = PHS_MAX_NAMES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic              last_word_i,
  input  logic [1:0]        sort_mode_i,
  output logic              done_o,
  output phs_snap_t         snap_o
);

  localparam int unsigned IDX_W     = $clog2(MAX_NAMES);
  localparam int unsigned LEN_W     = $clog2(MAX_NAMES + 1);
  localparam int unsigned OUT_DEPTH = (MAX_NAMES < OUT_MAX) ? MAX_NAMES : OUT_MAX;

  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_MIN   = 2'd1;
  localparam logic [1:0] PH_MAX   = 2'd2;
  localparam logic [1:0] PH_NAMES = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [WORD_W-1:0] remain_q, remain_d;
  logic [WORD_W-1:0] rec_len_q, rec_len_d;
  logic [WORD_W-1:0] min_depth_q, min_depth_d;
  logic              pend_q, pend_d;
  logic              first_q, first_d;
  logic [LEN_W-1:0]  best_len_q, best_len_d;
  logic [WORD_W-1:0] best_depth_q, best_depth_d;
  logic [MAX_NAMES-1:0][WORD_W-1:0] best_q, best_d;
  logic [MAX_NAMES-1:0][WORD_W-1:0] cand_q, cand_d;

  logic [WORD_W-1:0] pos_full;
  logic              pos_in;
  logic [IDX_W-1:0]  pos;
  logic [WORD_W-1:0] best_rd;
  logic              hit;
  logic              finish;
  logic              replace;
  logic [LEN_W-1:0]  count_len;
  logic [LEN_W-1:0]  rec_stored;

  // Clamp a name count to the stored depth
  function automatic logic [LEN_W-1:0] clamp_len(input logic [WORD_W-1:0] n);
    logic [LEN_W-1:0] r;
    if (n > WORD_W'(MAX_NAMES)) begin
      r = LEN_W'(MAX_NAMES);
    end else begin
      r = n[LEN_W-1:0];
    end
    return r;
  endfunction

  assign pos_full   = rec_len_q - remain_q;
  assign pos_in     = pos_full < WORD_W'(MAX_NAMES);
  assign pos        = pos_full[IDX_W-1:0];
  assign best_rd    = best_q[pos];
  assign count_len  = clamp_len(word_i);
  assign rec_stored = clamp_len(rec_len_q);

  // Name compare under the current sort mode
  always_comb begin
    hit = 1'b0;
    unique case (sort_mode_i)
      MODE_LEAST:  hit = best_rd > word_i;
      MODE_MOST:   hit = best_rd < word_i;
      MODE_SECOND: hit = (pos_full == WORD_W'(1)) && (best_rd < word_i);
      default:     hit = 1'b0;
    endcase
  end

  // Candidate store: write the incoming name at its position
  always_comb begin
    for (int i = 0; i < MAX_NAMES; i++) begin
      if (accept_i && phase_q == PH_NAMES && pos_in && pos == IDX_W'(i)) begin
        cand_d[i] = word_i;
      end else begin
        cand_d[i] = cand_q[i];
      end
    end
  end

  // Advance the record phase and fold finished records into the best list
  always_comb begin
    phase_d      = phase_q;
    remain_d     = remain_q;
    rec_len_d    = rec_len_q;
    min_depth_d  = min_depth_q;
    pend_d       = pend_q;
    first_d      = first_q;
    best_len_d   = best_len_q;
    best_depth_d = best_depth_q;
    best_d       = best_q;
    finish       = 1'b0;
    replace      = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        PH_COUNT: begin
          rec_len_d = word_i;
          remain_d  = word_i;
          pend_d    = first_q || (count_len > best_len_q);
          phase_d   = PH_MIN;
        end
        PH_MIN: begin
          min_depth_d = word_i;
          if (sort_mode_i == MODE_DEPTH && rec_len_q != '0 && best_depth_q > word_i) begin
            pend_d = 1'b1;
          end
          phase_d = PH_MAX;
        end
        PH_MAX: begin
          if (rec_len_q == '0) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_NAMES;
          end
        end
        default: begin
          if (pos_in && hit) begin
            pend_d = 1'b1;
          end
          remain_d = remain_q - WORD_W'(1);
          if (remain_d == '0) begin
            finish = 1'b1;
          end
        end
      endcase
    end

    if (finish) begin
      replace = pend_d;
      if (replace) begin
        for (int i = 0; i < MAX_NAMES; i++) begin
          if (LEN_W'(i) < rec_stored) begin
            best_d[i] = cand_d[i];
          end
        end
        if (rec_stored > best_len_q) begin
          best_len_d = rec_stored;
        end
        best_depth_d = min_depth_d;
      end
      first_d = 1'b0;
      pend_d  = 1'b0;
      phase_d = PH_COUNT;
    end
  end

  // Snapshot of the list as it stands after this word
  always_comb begin
    snap_o = '0;
    if (32'(best_len_d) > 32'(OUT_MAX)) begin
      snap_o.count = CNT_W'(OUT_MAX);
    end else begin
      snap_o.count = CNT_W'(best_len_d);
    end
    for (int i = 0; i < OUT_DEPTH; i++) begin
      snap_o.names[i] = best_d[i];
    end
  end

  assign done_o = accept_i && last_word_i;

  // Stream state; drop everything back to reset after the final word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_COUNT;
      remain_q     <= '0;
      rec_len_q    <= '0;
      min_depth_q  <= '0;
      pend_q       <= 1'b0;
      first_q      <= 1'b1;
      best_len_q   <= '0;
      best_depth_q <= '0;
      best_q       <= '0;
    end else if (done_o) begin
      phase_q      <= PH_COUNT;
      remain_q     <= '0;
      rec_len_q    <= '0;
      min_depth_q  <= '0;
      pend_q       <= 1'b0;
      first_q      <= 1'b1;
      best_len_q   <= '0;
      best_depth_q <= '0;
      best_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      remain_q     <= remain_d;
      rec_len_q    <= rec_len_d;
      min_depth_q  <= min_depth_d;
      pend_q       <= pend_d;
      first_q      <= first_d;
      best_len_q   <= best_len_d;
      best_depth_q <= best_depth_d;
      best_q       <= best_d;
    end
  end

  // Candidate names hold payload only
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

endmodule

// File: design/phs_burst.sv
// Result burst stage: holds a chosen list and sends it out one name per item.
`timescale 1ns / 1ps
module phs_burst
  import phs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  phs_snap_t snap_i,
  output logic      free_o,
  phs_out_if.source out_o
);

  logic                           busy_q;
  logic [POS_W-1:0]               idx_q;
  logic [CNT_W-1:0]               count_q;
  logic [OUT_MAX-1:0][WORD_W-1:0] names_q;
  logic                           last;
  logic                           fire;

  assign last = (count_q == '0) || ({1'b0, idx_q} + CNT_W'(1) == count_q);
  assign fire = busy_q && out_o.ready;

  assign out_o.valid         = busy_q;
  assign out_o.found         = count_q != '0;
  assign out_o.name_value    = (count_q == '0) ? '0 : names_q[idx_q];
  assign out_o.name_position = idx_q;
  assign out_o.last_name     = last;

  // Free while idle, or once the final item of the current list goes out
  assign free_o = !busy_q || (fire && last);

  // Burst control: load a new list or advance through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      count_q <= '0;
    end else if (load_i) begin
      busy_q  <= 1'b1;
      idx_q   <= '0;
      count_q <= snap_i.count;
    end else if (fire) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + POS_W'(1);
      end
    end
  end

  // List payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      names_q <= snap_i.names;
    end
  end

endmodule

// File: design/pick_hit_record_selector.sv
// Top level of the pick hit record selector: handshakes, sort mode register, checks.
// Takes one hit buffer word per cycle; each word is folded into the record state on accept.
// The first result item is valid the cycle after the final word is taken, then one item
// per cycle while the sink is ready: up to eight items, or one empty item if nothing hit.
// A final word waits while the previous list is still going out; other words never wait.
// Reset (async, active low) empties the list and sets the sort mode to nearest depth.
`timescale 1ns / 1ps
module pick_hit_record_selector
  import phs_pkg::*;
#(
  parameter int unsigned MAX_NAMES = PHS_MAX_NAMES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  phs_in_if.sink    in_i,
  phs_cfg_if.sink   cfg_i,
  phs_out_if.source out_o
);

  logic [1:0] mode_q;
  logic       burst_free;
  logic       accept;
  logic       done;
  phs_snap_t  snap;

  // Sort mode register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DEPTH;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.sort_mode;
    end
  end

  // Hold a final word until the result stage can take the list
  assign in_i.ready = !in_i.last_word || burst_free;
  assign accept     = in_i.valid && in_i.ready;

  phs_parser #(
    .MAX_NAMES(MAX_NAMES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .word_i     (in_i.word),
    .last_word_i(in_i.last_word),
    .sort_mode_i(mode_q),
    .done_o     (done),
    .snap_o     (snap)
  );

  phs_burst u_burst (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(done),
    .snap_i(snap),
    .free_o(burst_free),
    .out_o (out_o)
  );

  // An empty list is a single item
  a_empty_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.found |-> out_o.last_name && out_o.name_position == '0)
    else $error("empty list item not marked last at position zero");

  // A final word always yields a result item on the next cycle
  a_done_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_o.valid && out_o.name_position == '0)
    else $error("no result after final word");

  // Positions step by one inside a list
  a_pos_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_name |=>
      out_o.valid && out_o.name_position == $past(out_o.name_position) + 3'd1)
    else $error("name position did not advance");

  // A list ends cleanly when no new list is loaded
  a_burst_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.last_name && !done |=> !out_o.valid)
    else $error("result stage still busy after final item");

  // A final word is only taken when the result stage is free
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !done)
    else $error("list loaded over a stalled result");

endmodule
